// File: rtl/sha1h_pkg.sv
// Shared types and constants for the SHA-1 byte stream hasher.
// No dependencies; every other file in rtl imports this package.
package sha1h_pkg;

  localparam int NUM_ROUNDS   = 80;
  localparam int DIGEST_WORDS = 5;
  localparam int SCHED_WORDS  = 16;

  localparam logic [6:0] LAST_RND = 7'(NUM_ROUNDS - 1);
  localparam logic [6:0] GRP1_END = 7'd20;
  localparam logic [6:0] GRP2_END = 7'd40;
  localparam logic [6:0] GRP3_END = 7'd60;

  localparam logic [2:0] LAST_IDX = 3'(DIGEST_WORDS - 1);

  localparam logic [5:0] POS_FULL = 6'd63;
  localparam logic [5:0] POS_LEN  = 6'd56;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] K_GRP1 = 32'h5A827999;
  localparam logic [31:0] K_GRP2 = 32'h6ED9EBA1;
  localparam logic [31:0] K_GRP3 = 32'h8F1BBCDC;
  localparam logic [31:0] K_GRP4 = 32'hCA62C1D6;

  // Element 0 is H0.
  localparam logic [DIGEST_WORDS-1:0][31:0] SHA1_IV = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
  } sha1h_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha1h_out_t;

  typedef struct packed {
    logic       accept_byte;
    logic       pad;
    logic       len_blk;
    logic       load_work;
    logic       round;
    logic [6:0] rnd;
    logic       final_add;
    logic       emit;
  } sha1h_cmd_t;

  typedef struct packed {
    logic pos_full;
    logic pos_hi;
    logic emit_done;
  } sha1h_sts_t;

endpackage

// File: rtl/sha1h_dp.sv
// Datapath of the SHA-1 hasher: message schedule, round logic, chaining
// words, byte count and the digest output register. Depends on sha1h_pkg.
module sha1h_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  sha1h_pkg::sha1h_cmd_t cmd,
  input  logic [7:0]            data_byte,
  output sha1h_pkg::sha1h_sts_t sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sha1h_pkg::sha1h_out_t out_data
);
  import sha1h_pkg::*;

  logic [SCHED_WORDS-1:0][31:0]  sched;
  logic [SCHED_WORDS-1:0][31:0]  sched_next;
  logic [DIGEST_WORDS-1:0][31:0] chain;
  logic [DIGEST_WORDS-1:0][31:0] work;
  logic [60:0]                   byte_count;
  logic [2:0]                    out_idx;
  logic [5:0]                    pos;
  logic [63:0]                   bit_len;
  logic [31:0]                   f_val;
  logic [31:0]                   k_val;
  logic [31:0]                   tmp;
  logic [31:0]                   new_w;
  logic                          can_load;

  assign pos      = byte_count[5:0];
  assign bit_len  = {byte_count, 3'b000};
  assign can_load = !out_valid || out_ready;

  assign sts.pos_full  = (pos == POS_FULL);
  assign sts.pos_hi    = (pos >= POS_LEN);
  assign sts.emit_done = cmd.emit && can_load && (out_idx == LAST_IDX);

  // Round function and constant by round group.
  always_comb begin
    if (cmd.rnd < GRP1_END) begin
      f_val = work[3] ^ (work[1] & (work[2] ^ work[3]));
      k_val = K_GRP1;
    end else if (cmd.rnd < GRP2_END) begin
      f_val = work[1] ^ work[2] ^ work[3];
      k_val = K_GRP2;
    end else if (cmd.rnd < GRP3_END) begin
      f_val = (work[1] & work[2]) | (work[3] & (work[1] | work[2]));
      k_val = K_GRP3;
    end else begin
      f_val = work[1] ^ work[2] ^ work[3];
      k_val = K_GRP4;
    end
  end

  assign tmp = {work[0][26:0], work[0][31:27]} + f_val + work[4] + k_val + sched[0];

  always_comb begin
    new_w = sched[13] ^ sched[8] ^ sched[2] ^ sched[0];
    new_w = {new_w[30:0], new_w[31]};
  end

  // Block buffer doubles as a shift-line schedule: sched[0] is W[t].
  always_comb begin
    sched_next = sched;
    if (cmd.accept_byte) begin
      for (int w = 0; w < SCHED_WORDS; w++) begin
        for (int b = 0; b < 4; b++) begin
          if (6'(w * 4 + b) == pos) begin
            sched_next[w][8*(3-b) +: 8] = data_byte;
          end
        end
      end
    end
    if (cmd.pad) begin
      for (int w = 0; w < SCHED_WORDS; w++) begin
        for (int b = 0; b < 4; b++) begin
          if (6'(w * 4 + b) == pos) begin
            sched_next[w][8*(3-b) +: 8] = PAD_BYTE;
          end else if (6'(w * 4 + b) > pos) begin
            sched_next[w][8*(3-b) +: 8] = 8'h00;
          end
        end
      end
      if (!sts.pos_hi) begin
        sched_next[14] = bit_len[63:32];
        sched_next[15] = bit_len[31:0];
      end
    end
    if (cmd.len_blk) begin
      sched_next     = '0;
      sched_next[14] = bit_len[63:32];
      sched_next[15] = bit_len[31:0];
    end
    if (cmd.round) begin
      for (int w = 0; w < SCHED_WORDS - 1; w++) begin
        sched_next[w] = sched[w+1];
      end
      sched_next[SCHED_WORDS-1] = new_w;
    end
  end

  always_ff @(posedge clk) begin
    sched <= sched_next;
    if (cmd.load_work) begin
      work <= chain;
    end else if (cmd.round) begin
      work[0] <= tmp;
      work[1] <= work[0];
      work[2] <= {work[1][1:0], work[1][31:2]};
      work[3] <= work[2];
      work[4] <= work[3];
    end
    if (cmd.emit && can_load) begin
      out_data.digest_word <= chain[out_idx];
      out_data.word_index  <= out_idx;
      out_data.last_word   <= (out_idx == LAST_IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain      <= SHA1_IV;
      byte_count <= '0;
      out_idx    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.accept_byte) begin
        byte_count <= byte_count + 61'd1;
      end
      if (cmd.final_add) begin
        for (int i = 0; i < DIGEST_WORDS; i++) begin
          chain[i] <= chain[i] + work[i];
        end
      end
      if (cmd.emit && can_load) begin
        out_valid <= 1'b1;
        if (out_idx == LAST_IDX) begin
          // Digest copied out: restart for the next message.
          out_idx    <= '0;
          chain      <= SHA1_IV;
          byte_count <= '0;
        end else begin
          out_idx <= out_idx + 3'd1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/sha1h_ctrl.sv
// Controller of the SHA-1 hasher: input handshake, round sequencing,
// padding steps and digest emission. Depends on sha1h_pkg.
module sha1h_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  byte_valid,
  input  logic                  last,
  input  sha1h_pkg::sha1h_sts_t sts,
  output sha1h_pkg::sha1h_cmd_t cmd
);
  import sha1h_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ROUND = 6'b000010,
    S_FINAL = 6'b000100,
    S_PAD   = 6'b001000,
    S_LENB  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [6:0] rnd;
  logic       pend_pad;
  logic       pend_len;
  logic       pend_out;
  logic       accept;
  logic       compress_go;

  assign in_ready    = (state == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign compress_go = accept && byte_valid && sts.pos_full;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (compress_go) begin
          state_next = S_ROUND;
        end else if (accept && last) begin
          state_next = S_PAD;
        end
      end
      S_PAD:   state_next = S_ROUND;
      S_LENB:  state_next = S_ROUND;
      S_ROUND: begin
        if (rnd == LAST_RND) begin
          state_next = S_FINAL;
        end
      end
      S_FINAL: begin
        if (pend_pad) begin
          state_next = S_PAD;
        end else if (pend_len) begin
          state_next = S_LENB;
        end else if (pend_out) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (sts.emit_done) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rnd      <= '0;
      pend_pad <= 1'b0;
      pend_len <= 1'b0;
      pend_out <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_ROUND) begin
        rnd <= (rnd == LAST_RND) ? 7'd0 : rnd + 7'd1;
      end
      if (compress_go) begin
        pend_pad <= last;
      end
      if (state == S_PAD) begin
        pend_pad <= 1'b0;
        pend_len <= sts.pos_hi;
        pend_out <= 1'b1;
      end
      if (state == S_LENB) begin
        pend_len <= 1'b0;
      end
      if (sts.emit_done) begin
        pend_out <= 1'b0;
      end
    end
  end

  always_comb begin
    cmd.accept_byte = accept && byte_valid;
    cmd.pad         = (state == S_PAD);
    cmd.len_blk     = (state == S_LENB);
    cmd.load_work   = (state_next == S_ROUND) && (state != S_ROUND);
    cmd.round       = (state == S_ROUND);
    cmd.rnd         = rnd;
    cmd.final_add   = (state == S_FINAL);
    cmd.emit        = (state == S_EMIT);
  end

endmodule

// File: rtl/sha1_byte_stream_hasher.sv
// SHA-1 over a byte stream: one byte per input beat, five digest beats per
// message. Byte beats are taken while the controller is idle; the beat that
// fills a 64-byte block starts the rounds and the chaining add on the single
// round unit, during which no input is taken. A last beat starts a padding
// step and a round pass, plus a length block and another round pass when the
// length spills into a second block (64 - byte count mod 64 below 9), then
// five output beats, which wait while the output stalls.
// The last digest beat sits in the output register while the next message
// streams in. Depends on sha1h_pkg, sha1h_ctrl and sha1h_dp.
module sha1_byte_stream_hasher (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sha1h_pkg::sha1h_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sha1h_pkg::sha1h_out_t out_data
);
  import sha1h_pkg::*;

  sha1h_cmd_t cmd;
  sha1h_sts_t sts;

  sha1h_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .byte_valid (in_data.byte_valid),
    .last       (in_data.last),
    .sts        (sts),
    .cmd        (cmd)
  );

  sha1h_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .data_byte (in_data.data_byte),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Chaining add only right after the final round.
  a_final_after_rounds: assert property (@(posedge clk) disable iff (rst)
    cmd.final_add |-> $past(cmd.round && (cmd.rnd == LAST_RND)))
    else $error("chaining add without completed rounds");

  // A last beat that does not fill a block goes straight to padding.
  a_last_pads: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.last &&
     !(in_data.byte_valid && sts.pos_full)) |=> cmd.pad)
    else $error("last beat did not start padding");

  // No input is taken while the round unit is busy or the digest is emitted.
  a_no_accept_in_rounds: assert property (@(posedge clk) disable iff (rst)
    (cmd.round || cmd.final_add || cmd.emit) |-> !in_ready)
    else $error("input ready during compression or output");

endmodule

// File: verif/sha1_digest_checker.sv
`timescale 1ns / 1ps
// Digest checker for the SHA-1 byte stream hasher: watches both channels,
// predicts each message digest and compares every output beat with it.
// Depends on sha1h_pkg for the beat types and the SHA-1 constants.
module sha1_digest_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  sha1h_pkg::sha1h_in_t  in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  sha1h_pkg::sha1h_out_t out_data,
  output int                    fail_count,
  output int                    pending_words
);
  import sha1h_pkg::*;

  logic [4:0][31:0]  chain;
  logic [15:0][31:0] blk;
  logic [60:0]       nbytes;
  sha1h_out_t        digest_q[$];
  int                errors = 0;

  function automatic logic [15:0][31:0] put_byte(input logic [15:0][31:0] cur,
                                                  input logic [5:0] pos,
                                                  input logic [7:0] b);
    logic [15:0][31:0] nxt;
    nxt = cur;
    // big-endian: byte 0 of a word lands in bits 31:24
    nxt[pos[5:2]][{~pos[1:0], 3'b000} +: 8] = b;
    return nxt;
  endfunction

  function automatic logic [4:0][31:0] sha1_compress(input logic [4:0][31:0] h,
                                                      input logic [15:0][31:0] m);
    logic [15:0][31:0] w;
    logic [31:0]       a, b, c, d, e, f, k, x, t;
    logic [4:0][31:0]  nxt;
    int                r;
    w = m;
    a = h[0];
    b = h[1];
    c = h[2];
    d = h[3];
    e = h[4];
    for (r = 0; r < NUM_ROUNDS; r++) begin
      // extend the schedule in place over a 16-word window
      if (r >= 16) begin
        x = w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^ w[r % 16];
        w[r % 16] = {x[30:0], x[31]};
      end
      if (r < GRP1_END) begin
        f = d ^ (b & (c ^ d));
        k = K_GRP1;
      end else if (r < GRP2_END) begin
        f = b ^ c ^ d;
        k = K_GRP2;
      end else if (r < GRP3_END) begin
        f = (b & c) | (d & (b | c));
        k = K_GRP3;
      end else begin
        f = b ^ c ^ d;
        k = K_GRP4;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[r % 16];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    nxt[0] = h[0] + a;
    nxt[1] = h[1] + b;
    nxt[2] = h[2] + c;
    nxt[3] = h[3] + d;
    nxt[4] = h[4] + e;
    return nxt;
  endfunction

  always @(posedge clk) begin : track
    sha1h_out_t  want;
    logic [5:0]  pos;
    logic [63:0] bitlen;
    int          i;
    if (rst) begin
      chain  = SHA1_IV;
      blk    = '0;
      nbytes = '0;
      digest_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        if (in_data.byte_valid) begin
          pos    = nbytes[5:0];
          blk    = put_byte(blk, pos, in_data.data_byte);
          nbytes = nbytes + 61'd1;
          if (pos == POS_FULL) begin
            chain = sha1_compress(chain, blk);
          end
        end
        if (in_data.last) begin
          pos    = nbytes[5:0];
          bitlen = {nbytes, 3'b000};
          blk    = put_byte(blk, pos, PAD_BYTE);
          for (i = int'(pos) + 1; i < 64; i++) begin
            blk = put_byte(blk, 6'(i), 8'h00);
          end
          // no room for the length field: spill into a second block
          if (pos >= POS_LEN) begin
            chain = sha1_compress(chain, blk);
            blk   = '0;
          end
          blk[14] = bitlen[63:32];
          blk[15] = bitlen[31:0];
          chain   = sha1_compress(chain, blk);
          for (i = 0; i < DIGEST_WORDS; i++) begin
            want.digest_word = chain[i];
            want.word_index  = 3'(i);
            want.last_word   = (3'(i) == LAST_IDX);
            digest_q.push_back(want);
          end
          chain  = SHA1_IV;
          nbytes = '0;
        end
      end
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest beat, expected none, got %h", $time, out_data);
          errors++;
        end else begin
          want = digest_q.pop_front();
          if (out_data.digest_word !== want.digest_word) begin
            $display("%0t: digest_word[%0d] expected %h, got %h", $time,
                     want.word_index, want.digest_word, out_data.digest_word);
            errors++;
          end
          if (out_data.word_index !== want.word_index) begin
            $display("%0t: word_index expected %0d, got %0d", $time,
                     want.word_index, out_data.word_index);
            errors++;
          end
          if (out_data.last_word !== want.last_word) begin
            $display("%0t: last_word[%0d] expected %b, got %b", $time,
                     want.word_index, want.last_word, out_data.last_word);
            errors++;
          end
        end
      end
    end
    fail_count    <= errors;
    pending_words <= digest_q.size();
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Top of the SHA-1 byte stream hasher testbench: clock, reset, message
// stimulus with bursty input and stalling output, and the verdict.
// Depends on sha1h_pkg, sha1_byte_stream_hasher and sha1_digest_checker.
module tb_top;
  import sha1h_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_ITEMS = 460;

  localparam int RDY_OPEN     = 0;
  localparam int RDY_COIN     = 1;
  localparam int RDY_SPARSE   = 2;
  localparam int RDY_PERIODIC = 3;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid;
  logic       in_ready;
  sha1h_in_t  in_data;
  logic       out_valid;
  logic       out_ready = 1'b0;
  sha1h_out_t out_data;
  int         fail_count;
  int         pending_words;

  int cycles     = 0;
  int burst_left = 0;
  int items_sent = 0;
  int rdy_mode   = RDY_OPEN;
  int rdy_hold   = 0;

  sha1_byte_stream_hasher dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  sha1_digest_checker digest_chk (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending_words (pending_words)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Output stall pattern: switch to a random mode when the random hold count runs out.
  always @(posedge clk) begin
    if (rdy_hold == 0) begin
      rdy_mode <= $urandom_range(RDY_OPEN, RDY_PERIODIC);
      rdy_hold <= $urandom_range(16, 96);
    end else begin
      rdy_hold <= rdy_hold - 1;
    end
    case (rdy_mode)
      RDY_OPEN: begin
        out_ready <= 1'b1;
      end
      RDY_COIN: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      RDY_SPARSE: begin
        out_ready <= ($urandom_range(0, 7) == 0);
      end
      default: begin
        out_ready <= cycles[2];
      end
    endcase
  end

  // Hold the beat until accepted; drop valid only when the burst runs out.
  task automatic send_beat(input logic [7:0] d, input logic v, input logic l);
    sha1h_in_t beat;
    beat.data_byte  = d;
    beat.byte_valid = v;
    beat.last       = l;
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                               : $urandom_range(1, 10);
    end
  endtask

  task automatic send_message(input int len, input bit byte_on_last);
    int n;
    for (n = 0; n < len; n++) begin
      // sprinkle ignored beats inside the message
      if ($urandom_range(0, 11) == 0) begin
        send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      send_beat(8'($urandom_range(0, 255)), 1'b1, byte_on_last && (n == len - 1));
    end
    if (len == 0 || !byte_on_last) begin
      send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
  endtask

  initial begin : stimulus
    int len;
    int pick;
    in_valid <= 1'b0;
    in_data  <= '0;
    burst_left = $urandom_range(1, 10);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty message, with and without junk on the data lines
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'hFF, 1'b0, 1'b0);
    send_beat(8'hA5, 1'b0, 1'b1);
    // one-byte messages: byte on the last beat, and last on its own beat
    send_beat(8'h00, 1'b1, 1'b1);
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b1);
    // "abc"
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h63, 1'b1, 1'b1);
    // ignored beat in the middle of a message
    send_beat(8'h80, 1'b1, 1'b0);
    send_beat(8'h5A, 1'b0, 1'b0);
    send_beat(8'h7F, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);

    while (items_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2, 3: begin
          len = $urandom_range(0, 12);
        end
        4, 5, 6: begin
          // around the length-field boundary and the full block
          pick = $urandom_range(0, 5);
          len  = (pick < 3) ? 55 + pick : 60 + pick;
        end
        7: begin
          len = $urandom_range(0, 130);
        end
        8: begin
          pick = $urandom_range(0, 3);
          len  = (pick < 2) ? 119 + pick : 125 + pick;
        end
        default: begin
          len = $urandom_range(1, 40);
        end
      endcase
      // trim the final message so the run stays near its item budget
      if (len > RANDOM_ITEMS - items_sent) begin
        len = RANDOM_ITEMS - items_sent;
      end
      send_message(len, 1'($urandom_range(0, 1)));
    end
    if (in_valid) in_valid <= 1'b0;

    @(posedge clk);
    wait (pending_words == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/sha1h_pkg.sv
rtl/sha1h_dp.sv
rtl/sha1h_ctrl.sv
rtl/sha1_byte_stream_hasher.sv
verif/sha1_digest_checker.sv
verif/tb_top.sv
